### rtl/core/iad_pkg.sv
// ----------------------------------------------------------------------------
// iad_pkg
// Shared types and constants of the interval anomaly detector.
// ----------------------------------------------------------------------------
package iad_pkg;

  localparam int STAMP_W = 64;
  localparam int CNT_W   = 8;
  localparam int ADDR_W  = 2;
  localparam int DATA_W  = 32;

  localparam logic [CNT_W-1:0]  TRAINING_GAPS_RESET = 8'd10;
  localparam logic [ADDR_W-1:0] REG_TRAINING_GAPS   = 2'd0;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_TRAINED  = 2'd1,
    EV_DETECTED = 2'd2
  } event_t;

  typedef struct packed {
    event_t             event_code;
    logic [STAMP_W-1:0] gap_seen;
    logic [STAMP_W-1:0] midpoint_now;
    logic [STAMP_W-1:0] threshold_now;
    logic               model_ready;
  } result_t;

  typedef struct packed {
    logic             wr;
    logic [CNT_W-1:0] value;
  } cfg_wr_t;

endpackage

### rtl/core/iad_model.sv
// ----------------------------------------------------------------------------
// iad_model
// Gap model state and the single-pass update for one arrival stamp.
// ----------------------------------------------------------------------------
module iad_model
  import iad_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_wr_t            cfg,
  input  logic               step,
  input  logic [STAMP_W-1:0] stamp,
  output result_t            result,
  output logic [CNT_W-1:0]   training_gaps
);

  logic [STAMP_W-1:0] last_arrival, last_arrival_next;
  logic [STAMP_W-1:0] expected_gap, expected_gap_next;
  logic [STAMP_W-1:0] deviation_limit, deviation_limit_next;
  logic [CNT_W-1:0]   gaps_left, gaps_left_next;

  logic [STAMP_W-1:0] gap;
  logic [STAMP_W-1:0] dev;
  logic [STAMP_W:0]   avg_sum;
  logic [STAMP_W-1:0] avg;
  logic               exceeds;
  event_t             ev;

  always_comb begin
    gap     = (stamp > last_arrival) ? stamp - last_arrival : '0;
    dev     = (gap > expected_gap) ? gap - expected_gap : expected_gap - gap;
    avg_sum = {1'b0, expected_gap} + {1'b0, gap};
    avg     = avg_sum[STAMP_W:1];
    // twice the limit never overflows 64 bits unless the top bit is set
    exceeds = !deviation_limit[STAMP_W-1] &&
              (dev > {deviation_limit[STAMP_W-2:0], 1'b0});

    last_arrival_next    = last_arrival;
    expected_gap_next    = expected_gap;
    deviation_limit_next = deviation_limit;
    gaps_left_next       = gaps_left;
    ev                   = EV_NONE;

    if (stamp != '0) begin
      if (last_arrival == '0) begin
        last_arrival_next = stamp;
      end else if (expected_gap == '0) begin
        expected_gap_next = gap;
      end else begin
        last_arrival_next = stamp;
        if (gaps_left != '0) begin
          expected_gap_next = avg;
          if (dev > deviation_limit) deviation_limit_next = dev;
          gaps_left_next = gaps_left - 1'b1;
          if (gaps_left == CNT_W'(1)) ev = EV_TRAINED;
        end else if (exceeds) begin
          ev = EV_DETECTED;
        end else begin
          expected_gap_next = avg;
          if (dev > deviation_limit) deviation_limit_next = dev;
        end
      end
    end

    result.event_code    = ev;
    result.gap_seen      = ((stamp != '0) && (last_arrival != '0)) ? gap : '0;
    result.midpoint_now  = expected_gap_next;
    result.threshold_now = deviation_limit_next;
    result.model_ready   = (gaps_left_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      training_gaps   <= TRAINING_GAPS_RESET;
      gaps_left       <= TRAINING_GAPS_RESET;
      last_arrival    <= '0;
      expected_gap    <= '0;
      deviation_limit <= '0;
    end else if (cfg.wr) begin
      training_gaps <= cfg.value;
      gaps_left     <= cfg.value;
    end else if (step) begin
      gaps_left       <= gaps_left_next;
      last_arrival    <= last_arrival_next;
      expected_gap    <= expected_gap_next;
      deviation_limit <= deviation_limit_next;
    end
  end

endmodule

### rtl/core/interval_anomaly_detector.sv
// ----------------------------------------------------------------------------
// interval_anomaly_detector
// Learns the usual gap between packet arrival stamps and flags outliers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one arrival_stamp per item.
//   Output channel out_valid/out_ready returns exactly one result per item:
//   event_code, gap_seen, midpoint_now, threshold_now and model_ready.
//   An item is held in the input register, where the model update is done,
//   and its result is then registered in the output register: throughput
//   one item per cycle while the receiver does not stall, set by the single
//   combinational update between the two registers; the model state is
//   written at the same edge as the result. When the receiver stalls, the
//   result waits in the output register, the next item waits in the input
//   register, and in_ready drops once both are full. Reset clears the model
//   and loads training_gaps with 10; the block takes items as soon as reset
//   is released.
//   training_gaps is at APB address 0; a write restarts the training count.
//   The user makes writes only while no item is in flight (not enforced).
// ----------------------------------------------------------------------------
module interval_anomaly_detector
  import iad_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [STAMP_W-1:0] arrival_stamp,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         event_code,
  output logic [STAMP_W-1:0] gap_seen,
  output logic [STAMP_W-1:0] midpoint_now,
  output logic [STAMP_W-1:0] threshold_now,
  output logic               model_ready,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic               s1_valid;
  logic [STAMP_W-1:0] s1_stamp;
  logic               advance;
  result_t            res_comb;
  result_t            res_q;
  cfg_wr_t            cfg;
  logic [CNT_W-1:0]   training_gaps;

  assign pready    = 1'b1;
  assign cfg.wr    = psel && penable && pwrite && (paddr == REG_TRAINING_GAPS);
  assign cfg.value = pwdata[CNT_W-1:0];
  assign prdata    = (paddr == REG_TRAINING_GAPS) ?
                     {{(DATA_W-CNT_W){1'b0}}, training_gaps} : '0;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_stamp <= arrival_stamp;
  end

  iad_model u_model (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .step          (advance),
    .stamp         (s1_stamp),
    .result        (res_comb),
    .training_gaps (training_gaps)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_q <= res_comb;
  end

  assign event_code    = res_q.event_code;
  assign gap_seen      = res_q.gap_seen;
  assign midpoint_now  = res_q.midpoint_now;
  assign threshold_now = res_q.threshold_now;
  assign model_ready   = res_q.model_ready;

`ifndef SYNTHESIS
  a_detect_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && (res_q.event_code == EV_DETECTED) |-> res_q.model_ready)
    else $error("detection reported before the model is ready");

  a_trained_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && (res_q.event_code == EV_TRAINED) |-> res_q.model_ready)
    else $error("trained event without model ready");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_q))
    else $error("result lost while receiver stalls");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input blocked without a full pipeline");
`endif

endmodule

### test/interval_anomaly_detector_tb.sv
// ----------------------------------------------------------------------------
// interval_anomaly_detector_tb
// Sends arrival stamps with random gaps and output stalls. A gap model kept in
// the bench predicts every result, and each output field is compared in order.
// ----------------------------------------------------------------------------
module interval_anomaly_detector_tb;
  import iad_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_IDLE     = 13;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [STAMP_W-1:0] arrival_stamp;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         event_code;
  logic [STAMP_W-1:0] gap_seen;
  logic [STAMP_W-1:0] midpoint_now;
  logic [STAMP_W-1:0] threshold_now;
  logic               model_ready;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  // gap model state, mirrors the block
  logic [CNT_W-1:0]   train_cfg;
  logic [CNT_W-1:0]   gaps_todo;
  logic [STAMP_W-1:0] prev_stamp;
  logic [STAMP_W-1:0] mid_gap;
  logic [STAMP_W-1:0] dev_limit;

  result_t pending_results[$];
  int      mismatches = 0;
  int      cycles = 0;
  bit      gapless = 1'b0;

  interval_anomaly_detector dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_cycles();
    return gapless ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic void check_field(string fld, logic [STAMP_W-1:0] want,
                                      logic [STAMP_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%s mismatch: expected %0h, got %0h", fld, want, got);
    end
  endfunction

  function automatic void absorb_gap(logic [STAMP_W-1:0] gap, logic [STAMP_W-1:0] dev);
    logic [STAMP_W:0] sum;
    sum     = {1'b0, mid_gap} + {1'b0, gap};
    mid_gap = sum[STAMP_W:1];
    if (dev > dev_limit)
      dev_limit = dev;
  endfunction

  function automatic result_t advance_gap_model(logic [STAMP_W-1:0] stamp);
    result_t            r;
    event_t             ev;
    logic [STAMP_W-1:0] gap;
    logic [STAMP_W-1:0] dev;
    ev  = EV_NONE;
    gap = '0;
    if (stamp != '0) begin
      if (prev_stamp == '0) begin
        prev_stamp = stamp;
      end else begin
        gap = (stamp > prev_stamp) ? stamp - prev_stamp : '0;
        if (mid_gap == '0) begin
          // empty midpoint is loaded, previous stamp kept
          mid_gap = gap;
        end else begin
          dev = (gap > mid_gap) ? gap - mid_gap : mid_gap - gap;
          if (gaps_todo != '0) begin
            absorb_gap(gap, dev);
            gaps_todo = gaps_todo - 1'b1;
            if (gaps_todo == '0)
              ev = EV_TRAINED;
          end else if ({1'b0, dev} > {dev_limit, 1'b0}) begin
            ev = EV_DETECTED;
          end else begin
            absorb_gap(gap, dev);
          end
          prev_stamp = stamp;
        end
      end
    end
    r.event_code    = ev;
    r.gap_seen      = gap;
    r.midpoint_now  = mid_gap;
    r.threshold_now = dev_limit;
    r.model_ready   = (gaps_todo == '0);
    return r;
  endfunction

  task automatic send_stamp(input logic [STAMP_W-1:0] stamp);
    int n;
    n = idle_cycles();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid      <= 1'b1;
    arrival_stamp <= stamp;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(advance_gap_model(stamp));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write, then read back through a second transfer
  task automatic write_training_gaps(input logic [CNT_W-1:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_TRAINING_GAPS;
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    train_cfg = value;
    gaps_todo = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field("training_gaps", STAMP_W'(train_cfg), STAMP_W'(prdata[CNT_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_startup_sequence();
    send_stamp('0);
    send_stamp(64'd100);
    send_stamp('0);
    send_stamp(64'd100);  // same stamp: zero gap, midpoint still empty
    send_stamp(64'd101);  // loads midpoint, previous stamp kept
    send_stamp(64'd100);  // earlier stamp, average drops midpoint back to zero
    send_stamp(64'd110);
    for (int i = 0; i < 10; i++)
      send_stamp(prev_stamp + 64'd10 + STAMP_W'(i % 3));
    send_stamp(prev_stamp + 64'd1000);
    send_stamp(prev_stamp - 64'd5);
    send_stamp('1);
    send_stamp(64'd5000);
    send_stamp(64'd5011);
  endtask

  task automatic test_random_traffic();
    int                 sent;
    int                 phase_len;
    int                 pick;
    logic [STAMP_W-1:0] period;
    logic [STAMP_W-1:0] jitter;
    logic [STAMP_W-1:0] stamp;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      write_training_gaps(CNT_W'($urandom_range(1, 24)));
      gapless = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0)
        period = {32'd0, $urandom} | 64'd1;
      else
        period = STAMP_W'($urandom_range(2, 5000));
      jitter    = period >> $urandom_range(3, 8);
      phase_len = $urandom_range(40, 160);
      for (int i = 0; i < phase_len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          send_stamp('0);
        end else begin
          // noise and outliers only once trained, so the limit stays usable
          if (pick < 10 && gaps_todo == '0)
            stamp = {$urandom, $urandom};
          else if (pick < 22 && gaps_todo == '0)
            stamp = prev_stamp + period + (dev_limit << 2) +
                    {24'd0, 8'($urandom), $urandom};
          else
            stamp = prev_stamp + period - jitter +
                    STAMP_W'($urandom) % (2 * jitter + 1);
          send_stamp(stamp);
          sent++;
        end
      end
    end
    gapless = 1'b0;
  endtask

  task automatic test_wide_values();
    gapless = 1'b1;
    write_training_gaps('0);  // ready at once, no trained event
    send_stamp(prev_stamp + mid_gap);
    write_training_gaps('1);
    send_stamp(prev_stamp + mid_gap);
    send_stamp(prev_stamp + mid_gap + 64'd1);
    write_training_gaps(8'd2);
    send_stamp(64'd1);
    send_stamp('1);  // near full-range gap: limit gets its top bit set
    send_stamp(64'd1);
    send_stamp('1);
    send_stamp(64'h8000_0000_0000_0000);
    gapless = 1'b0;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with no item pending: event %0d gap %0h",
                   event_code, gap_seen);
      end else begin
        want = pending_results.pop_front();
        check_field("event_code", STAMP_W'(want.event_code), STAMP_W'(event_code));
        check_field("gap_seen", want.gap_seen, gap_seen);
        check_field("midpoint_now", want.midpoint_now, midpoint_now);
        check_field("threshold_now", want.threshold_now, threshold_now);
        check_field("model_ready", STAMP_W'(want.model_ready), STAMP_W'(model_ready));
      end
    end
  end

  // receiver: a random stall, which may be empty, before every result
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = idle_cycles();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    arrival_stamp = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    train_cfg     = TRAINING_GAPS_RESET;
    gaps_todo     = TRAINING_GAPS_RESET;
    prev_stamp    = '0;
    mid_gap       = '0;
    dev_limit     = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_startup_sequence();
    test_random_traffic();
    test_wide_values();
    settle();
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
